// ----- src/gsrs_pkg.sv -----
// Shared types, constants and tables of the surface reaction step block.
package gsrs_pkg;

  localparam int POP_BITS       = 20;
  localparam int RATE_FRAC_BITS = 20;
  localparam int NSPEC          = 6;
  localparam int NEV            = 7;
  localparam int RATE_W         = 32;
  localparam int TIME_W         = 48;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_W          = 48;
  localparam int EV_W           = 3;
  localparam int SP_W           = 3;

  localparam int PP_W    = 2 * POP_BITS;
  localparam int PROP_W  = RATE_W + PP_W;
  localparam int TOT_W   = PROP_W + 3;
  localparam int NLIMB   = (TOT_W + 31) / 32;
  localparam int LIMB_W  = 32 * NLIMB;
  localparam int ACC_W   = 32 * (NLIMB + 1);
  localparam int WIDE_W  = (TOT_W > 64) ? TOT_W : 65;

  localparam int LOG2_FRAC  = 28;
  localparam int NORM_STEPS = 6;
  localparam int LN_W       = 29;
  localparam int DT_SHIFT   = RATE_FRAC_BITS - 4;
  localparam int DVD_W      = LN_W + DT_SHIFT;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int SUM_W      = ((DVD_W > TIME_W) ? DVD_W : TIME_W) + 1;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 4'd7;

  typedef enum logic [SP_W-1:0] {
    SP_GAS, SP_FREE_ADS, SP_STRONG_ADS, SP_FREE_SITE, SP_STRONG_SITE, SP_MOLECULE
  } species_e;

  typedef enum logic [EV_W-1:0] {
    EV_ADSORB_FREE, EV_DESORB_FREE, EV_ADSORB_STRONG, EV_ELEY_RIDEAL,
    EV_DIFFUSE, EV_LH_MIXED, EV_LH_FREE
  } event_e;

  typedef enum logic [1:0] {
    ST_FIRED       = 2'd0,
    ST_NO_REACTION = 2'd1,
    ST_TIME_LIMIT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_CHECK, CS_PROP_MUL, CS_PROP_K, CS_PROP_ACC, CS_ZERO_CHK,
    CS_THR_MUL, CS_THR_FIN, CS_SELECT, CS_WAIT_LOG, CS_DIVIDE, CS_FINAL, CS_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_SQUARE, LG_SCALE
  } log_phase_e;

  typedef struct packed {
    logic            load;
    logic            capture;
    logic            log_start;
    logic            prop_mul;
    logic            prop_k;
    logic            prop_acc;
    logic            thr_mul;
    logic            thr_fin;
    logic            sel;
    logic            div_start;
    logic            commit;
    logic            apply;
    logic            set_finished;
    logic            emit;
    logic [EV_W-1:0] idx;
    status_e         status;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic time_reached;
    logic total_zero;
    logic total_big;
    logic log_done;
    logic div_done;
    logic t_over;
    logic sel_hit;
  } dp_status_t;

  localparam logic [2:0] DZ  = 3'b000;
  localparam logic [2:0] DP1 = 3'b001;
  localparam logic [2:0] DP2 = 3'b010;
  localparam logic [2:0] DN1 = 3'b111;
  localparam logic [2:0] DN2 = 3'b110;

  // Population changes of one event, 3-bit two's complement per species,
  // species 0 in the low bits.
  function automatic logic [3*NSPEC-1:0] ev_delta(input logic [EV_W-1:0] ev);
    logic [3*NSPEC-1:0] row;
    row = '0;
    case (ev)
      EV_ADSORB_FREE:   row = {DZ,  DZ,  DN1, DZ,  DP1, DN1};
      EV_DESORB_FREE:   row = {DZ,  DZ,  DP1, DZ,  DN1, DP1};
      EV_ADSORB_STRONG: row = {DZ,  DN1, DZ,  DP1, DZ,  DN1};
      EV_ELEY_RIDEAL:   row = {DP1, DP1, DZ,  DN1, DZ,  DN1};
      EV_DIFFUSE:       row = {DZ,  DN1, DP1, DP1, DN1, DZ };
      EV_LH_MIXED:      row = {DP1, DP1, DP1, DN1, DN1, DZ };
      EV_LH_FREE:       row = {DP1, DZ,  DP2, DZ,  DN2, DZ };
      default:          row = '0;
    endcase
    return row;
  endfunction

endpackage

// ----- src/gsrs_log.sv -----
// Iterative -ln(u) unit: normalize, square for log2 bits, scale by ln 2.
module gsrs_log (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                value_i,
  output logic                       done_o,
  output logic [gsrs_pkg::LN_W-1:0]  neg_ln_o
);

  gsrs_pkg::log_phase_e phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  logic [32:0] mant_q, mant_n;
  logic [5:0]  exp_q, exp_n;
  logic [31:0] m_q;
  logic [gsrs_pkg::LOG2_FRAC-1:0] frac_q;
  logic [gsrs_pkg::LN_W-1:0] ln_q;

  logic [5:0]  sh;
  logic        top_zero;
  logic [63:0] sq;
  logic [32:0] sq_hi;
  logic [33:0] y;
  logic [63:0] scaled;

  always_comb begin
    sh       = 6'd32 >> cnt_q[2:0];
    top_zero = (mant_q >> (6'd33 - sh)) == 33'd0;
    mant_n   = top_zero ? (mant_q << sh) : mant_q;
    exp_n    = top_zero ? (exp_q - sh) : exp_q;
    sq       = 64'(m_q) * 64'(m_q);
    sq_hi    = sq[63:31];
    y        = 34'h2_0000_0000 - 34'({exp_q, frac_q});
    scaled   = 64'(y) * 64'(gsrs_pkg::LN2_Q30);
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    unique case (phase_q)
      gsrs_pkg::LG_IDLE: ;
      gsrs_pkg::LG_NORM: begin
        if (cnt_q == 5'(gsrs_pkg::NORM_STEPS - 1)) begin
          phase_d = gsrs_pkg::LG_SQUARE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gsrs_pkg::LG_SQUARE: begin
        if (cnt_q == 5'(gsrs_pkg::LOG2_FRAC - 1)) begin
          phase_d = gsrs_pkg::LG_SCALE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gsrs_pkg::LG_SCALE: begin
        phase_d = gsrs_pkg::LG_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = gsrs_pkg::LG_IDLE;
    endcase
    if (start_i) begin
      phase_d = gsrs_pkg::LG_NORM;
      cnt_d   = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gsrs_pkg::LG_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mant_q <= 33'(value_i) + 33'd1;
      exp_q  <= 6'd32;
      frac_q <= '0;
    end else begin
      case (phase_q)
        gsrs_pkg::LG_NORM: begin
          mant_q <= mant_n;
          exp_q  <= exp_n;
          m_q    <= mant_n[32:1];
        end
        gsrs_pkg::LG_SQUARE: begin
          m_q    <= sq_hi[32] ? sq_hi[32:1] : sq_hi[31:0];
          frac_q <= {frac_q[gsrs_pkg::LOG2_FRAC-2:0], sq_hi[32]};
        end
        gsrs_pkg::LG_SCALE: ln_q <= scaled[34 +: gsrs_pkg::LN_W];
        default: ;
      endcase
    end
  end

  assign done_o   = done_q;
  assign neg_ln_o = ln_q;

endmodule

// ----- src/gsrs_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gsrs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gsrs_pkg::DVD_W-1:0]  dividend_i,
  input  logic [63:0]                 divisor_i,
  output logic                        done_o,
  output logic [gsrs_pkg::DVD_W-1:0]  quotient_o
);

  logic                              busy_q, done_q;
  logic [gsrs_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [64:0]                       rem_q, rem_sh, rem_nx;
  logic [gsrs_pkg::DVD_W-1:0]        quo_q;
  logic [63:0]                       dsr_q;
  logic                              ge;

  always_comb begin
    rem_sh = {rem_q[63:0], quo_q[gsrs_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == gsrs_pkg::DIV_CNT_W'(gsrs_pkg::DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[gsrs_pkg::DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/gsrs_datapath.sv -----
// Step datapath: state, config registers, propensities, threshold, event update.
module gsrs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsrs_pkg::dp_cmd_t                   cmd_i,
  output gsrs_pkg::dp_status_t                status_o,
  input  logic [gsrs_pkg::SP_W-1:0]           species_index_i,
  input  logic [gsrs_pkg::POP_BITS-1:0]       population_i,
  input  logic [31:0]                         uniform_a_i,
  input  logic [31:0]                         uniform_b_i,
  input  logic                                cfg_we_i,
  input  logic [gsrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gsrs_pkg::CFG_W-1:0]          cfg_data_i,
  output logic [1:0]                          status_out_o,
  output logic [gsrs_pkg::EV_W-1:0]           event_out_o,
  output logic [gsrs_pkg::TIME_W-1:0]         time_out_o,
  output logic [gsrs_pkg::NSPEC-1:0][gsrs_pkg::POP_BITS-1:0] pop_out_o
);

  localparam int PB = gsrs_pkg::POP_BITS;

  logic [PB-1:0]                    sp_q [gsrs_pkg::NSPEC];
  logic [gsrs_pkg::TIME_W-1:0]      sim_q;
  logic                             fin_q;
  logic [gsrs_pkg::RATE_W-1:0]      rate_q [gsrs_pkg::NEV];
  logic [gsrs_pkg::TIME_W-1:0]      limit_q;

  logic [31:0]                      ua_q, ub_q;
  logic [gsrs_pkg::PP_W-1:0]        pp_q;
  logic [63:0]                      klo_q, khi_q;
  logic [gsrs_pkg::PROP_W-1:0]      prop_q [gsrs_pkg::NEV];
  logic [gsrs_pkg::TOT_W-1:0]       total_q, thr_q, cum_q;
  logic [gsrs_pkg::ACC_W-1:0]       acc_q;
  logic [gsrs_pkg::EV_W-1:0]        chosen_q;

  logic [PB-1:0]                    pa, pb;
  logic [63:0]                      pp64, pprod;
  logic [gsrs_pkg::PROP_W-1:0]      prop_new, prop_rd;
  logic [gsrs_pkg::LIMB_W-1:0]      tot_limbs;
  logic [31:0]                      limb;
  logic [gsrs_pkg::ACC_W-1:0]       pprod_sh;
  logic [gsrs_pkg::TOT_W-1:0]       cum_n;
  logic [gsrs_pkg::WIDE_W-1:0]      tot_wide;
  logic                             total_big;
  logic                             log_done, div_done;
  logic [gsrs_pkg::LN_W-1:0]        neg_ln;
  logic [gsrs_pkg::DVD_W-1:0]       quot, dt;
  logic [gsrs_pkg::SUM_W-1:0]       t_sum;
  logic [gsrs_pkg::TIME_W-1:0]      t_new;
  logic [3*gsrs_pkg::NSPEC-1:0]     drow;
  logic [PB-1:0]                    sp_new [gsrs_pkg::NSPEC];

  gsrs_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.log_start),
    .value_i  (ua_q),
    .done_o   (log_done),
    .neg_ln_o (neg_ln)
  );

  gsrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (gsrs_pkg::DVD_W'(neg_ln) << gsrs_pkg::DT_SHIFT),
    .divisor_i  (tot_wide[63:0]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Population factors of each event; a unity factor stands for one population.
  always_comb begin
    pa = '0;
    pb = '0;
    case (cmd_i.idx)
      gsrs_pkg::EV_ADSORB_FREE:   begin pa = sp_q[gsrs_pkg::SP_GAS];
                                        pb = sp_q[gsrs_pkg::SP_FREE_SITE];   end
      gsrs_pkg::EV_DESORB_FREE:   begin pa = sp_q[gsrs_pkg::SP_FREE_ADS];
                                        pb = PB'(1);                          end
      gsrs_pkg::EV_ADSORB_STRONG: begin pa = sp_q[gsrs_pkg::SP_GAS];
                                        pb = sp_q[gsrs_pkg::SP_STRONG_SITE]; end
      gsrs_pkg::EV_ELEY_RIDEAL:   begin pa = sp_q[gsrs_pkg::SP_GAS];
                                        pb = sp_q[gsrs_pkg::SP_STRONG_ADS];  end
      gsrs_pkg::EV_DIFFUSE:       begin pa = sp_q[gsrs_pkg::SP_FREE_ADS];
                                        pb = sp_q[gsrs_pkg::SP_STRONG_SITE]; end
      gsrs_pkg::EV_LH_MIXED:      begin pa = sp_q[gsrs_pkg::SP_FREE_ADS];
                                        pb = sp_q[gsrs_pkg::SP_STRONG_ADS];  end
      gsrs_pkg::EV_LH_FREE:       begin pa = sp_q[gsrs_pkg::SP_FREE_ADS];
                                        pb = sp_q[gsrs_pkg::SP_FREE_ADS];    end
      default: ;
    endcase
  end

  always_comb begin
    pp64      = 64'(pp_q);
    prop_new  = gsrs_pkg::PROP_W'(96'(klo_q) + (96'(khi_q) << 32));
    prop_rd   = prop_q[cmd_i.idx];
    tot_limbs = gsrs_pkg::LIMB_W'(total_q);
    limb      = tot_limbs[32*cmd_i.idx +: 32];
    pprod     = 64'(limb) * 64'(ub_q);
    pprod_sh  = gsrs_pkg::ACC_W'(pprod) << (32 * cmd_i.idx);
    cum_n     = cum_q + gsrs_pkg::TOT_W'(prop_rd);
    tot_wide  = gsrs_pkg::WIDE_W'(total_q);
    total_big = |tot_wide[gsrs_pkg::WIDE_W-1:64];
    dt        = total_big ? '0 : quot;
    t_sum     = gsrs_pkg::SUM_W'(sim_q) + gsrs_pkg::SUM_W'(dt);
    t_new     = (t_sum > gsrs_pkg::SUM_W'({gsrs_pkg::TIME_W{1'b1}}))
                ? {gsrs_pkg::TIME_W{1'b1}} : t_sum[gsrs_pkg::TIME_W-1:0];
    drow      = gsrs_pkg::ev_delta(chosen_q);
  end

  // Apply the chosen event per species, clamped at zero and at the maximum.
  always_comb begin
    logic signed [PB+1:0] v;
    for (int s = 0; s < gsrs_pkg::NSPEC; s++) begin
      v = $signed({2'b00, sp_q[s]}) + (PB+2)'($signed(drow[3*s +: 3]));
      if (v < 0) begin
        sp_new[s] = '0;
      end else if (v > $signed({2'b00, {PB{1'b1}}})) begin
        sp_new[s] = {PB{1'b1}};
      end else begin
        sp_new[s] = v[PB-1:0];
      end
    end
  end

  always_comb begin
    status_o.finished     = fin_q;
    status_o.time_reached = sim_q >= limit_q;
    status_o.total_zero   = total_q == '0;
    status_o.total_big    = total_big;
    status_o.log_done     = log_done;
    status_o.div_done     = div_done;
    status_o.t_over       = t_new > limit_q;
    status_o.sel_hit      = (prop_rd != '0) && (cum_n >= thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < gsrs_pkg::NSPEC; s++) sp_q[s] <= '0;
      for (int e = 0; e < gsrs_pkg::NEV; e++) rate_q[e] <= '0;
      sim_q   <= '0;
      fin_q   <= 1'b0;
      limit_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i < gsrs_pkg::CFG_IDX_W'(gsrs_pkg::NEV)) begin
          rate_q[cfg_index_i[gsrs_pkg::EV_W-1:0]] <= cfg_data_i[gsrs_pkg::RATE_W-1:0];
        end else if (cfg_index_i == gsrs_pkg::REG_TIME_LIMIT) begin
          limit_q <= cfg_data_i[gsrs_pkg::TIME_W-1:0];
        end
      end
      // Drop loads to species codes beyond the last one.
      if (cmd_i.load && (species_index_i < gsrs_pkg::SP_W'(gsrs_pkg::NSPEC))) begin
        sp_q[species_index_i] <= population_i;
        sim_q <= '0;
        fin_q <= 1'b0;
      end
      if (cmd_i.commit) sim_q <= t_new;
      if (cmd_i.set_finished) fin_q <= 1'b1;
      if (cmd_i.apply) begin
        for (int s = 0; s < gsrs_pkg::NSPEC; s++) sp_q[s] <= sp_new[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ua_q     <= uniform_a_i;
      ub_q     <= uniform_b_i;
      total_q  <= '0;
      acc_q    <= '0;
      cum_q    <= '0;
      chosen_q <= '0;
    end
    if (cmd_i.prop_mul) pp_q <= gsrs_pkg::PP_W'(pa) * gsrs_pkg::PP_W'(pb);
    if (cmd_i.prop_k) begin
      klo_q <= 64'(rate_q[cmd_i.idx]) * 64'(pp64[31:0]);
      khi_q <= 64'(rate_q[cmd_i.idx]) * 64'(pp64[63:32]);
    end
    if (cmd_i.prop_acc) begin
      prop_q[cmd_i.idx] <= prop_new;
      total_q <= total_q + gsrs_pkg::TOT_W'(prop_new);
    end
    if (cmd_i.thr_mul) acc_q <= acc_q + pprod_sh;
    if (cmd_i.thr_fin) begin
      thr_q <= gsrs_pkg::TOT_W'(acc_q[gsrs_pkg::ACC_W-1:32])
             + gsrs_pkg::TOT_W'(|acc_q[31:0]);
    end
    if (cmd_i.sel) begin
      cum_q <= cum_n;
      if (status_o.sel_hit) chosen_q <= cmd_i.idx;
    end
    if (cmd_i.emit) begin
      status_out_o <= cmd_i.status;
      event_out_o  <= (cmd_i.status == gsrs_pkg::ST_FIRED) ? chosen_q : '0;
      time_out_o   <= sim_q;
      for (int s = 0; s < gsrs_pkg::NSPEC; s++) pop_out_o[s] <= sp_q[s];
    end
  end

endmodule

// ----- src/gsrs_ctrl.sv -----
// Step sequencer: orders the datapath phases and owns the output handshake.
module gsrs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_cmd_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  input  gsrs_pkg::dp_status_t   dp_status_i,
  output gsrs_pkg::dp_cmd_t      dp_cmd_o
);

  gsrs_pkg::ctrl_state_e     state_q, state_d;
  logic [gsrs_pkg::EV_W-1:0] idx_q, idx_d;
  gsrs_pkg::status_e         status_q, status_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;

  localparam logic [gsrs_pkg::EV_W-1:0] LAST_EV   = gsrs_pkg::EV_W'(gsrs_pkg::NEV - 1);
  localparam logic [gsrs_pkg::EV_W-1:0] LAST_LIMB = gsrs_pkg::EV_W'(gsrs_pkg::NLIMB - 1);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    status_d = status_q;
    unique case (state_q)
      gsrs_pkg::CS_IDLE: begin
        if (in_valid_i && (in_cmd_i == gsrs_pkg::CMD_STEP)) state_d = gsrs_pkg::CS_CHECK;
      end
      gsrs_pkg::CS_CHECK: begin
        if (dp_status_i.finished) begin
          status_d = dp_status_i.time_reached ? gsrs_pkg::ST_TIME_LIMIT
                                              : gsrs_pkg::ST_NO_REACTION;
          state_d  = gsrs_pkg::CS_EMIT;
        end else if (dp_status_i.time_reached) begin
          status_d = gsrs_pkg::ST_TIME_LIMIT;
          state_d  = gsrs_pkg::CS_EMIT;
        end else begin
          idx_d   = '0;
          state_d = gsrs_pkg::CS_PROP_MUL;
        end
      end
      gsrs_pkg::CS_PROP_MUL: state_d = gsrs_pkg::CS_PROP_K;
      gsrs_pkg::CS_PROP_K:   state_d = gsrs_pkg::CS_PROP_ACC;
      gsrs_pkg::CS_PROP_ACC: begin
        if (idx_q == LAST_EV) begin
          idx_d   = '0;
          state_d = gsrs_pkg::CS_ZERO_CHK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = gsrs_pkg::CS_PROP_MUL;
        end
      end
      gsrs_pkg::CS_ZERO_CHK: begin
        if (dp_status_i.total_zero) begin
          status_d = gsrs_pkg::ST_NO_REACTION;
          state_d  = gsrs_pkg::CS_EMIT;
        end else begin
          state_d = gsrs_pkg::CS_THR_MUL;
        end
      end
      gsrs_pkg::CS_THR_MUL: begin
        if (idx_q == LAST_LIMB) begin
          state_d = gsrs_pkg::CS_THR_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      gsrs_pkg::CS_THR_FIN: begin
        idx_d   = '0;
        state_d = gsrs_pkg::CS_SELECT;
      end
      gsrs_pkg::CS_SELECT: begin
        if (dp_status_i.sel_hit || (idx_q == LAST_EV)) begin
          state_d = gsrs_pkg::CS_WAIT_LOG;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      gsrs_pkg::CS_WAIT_LOG: begin
        if (dp_status_i.log_done) begin
          state_d = dp_status_i.total_big ? gsrs_pkg::CS_FINAL : gsrs_pkg::CS_DIVIDE;
        end
      end
      gsrs_pkg::CS_DIVIDE: begin
        if (dp_status_i.div_done) state_d = gsrs_pkg::CS_FINAL;
      end
      gsrs_pkg::CS_FINAL: begin
        status_d = dp_status_i.t_over ? gsrs_pkg::ST_TIME_LIMIT : gsrs_pkg::ST_FIRED;
        state_d  = gsrs_pkg::CS_EMIT;
      end
      gsrs_pkg::CS_EMIT: begin
        if (out_free) state_d = gsrs_pkg::CS_IDLE;
      end
      default: state_d = gsrs_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o        = '0;
    dp_cmd_o.idx    = idx_q;
    dp_cmd_o.status = status_q;
    unique case (state_q)
      gsrs_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.load    = (in_cmd_i == gsrs_pkg::CMD_LOAD);
          dp_cmd_o.capture = (in_cmd_i == gsrs_pkg::CMD_STEP);
        end
      end
      gsrs_pkg::CS_CHECK: begin
        dp_cmd_o.set_finished = !dp_status_i.finished && dp_status_i.time_reached;
        dp_cmd_o.log_start    = !dp_status_i.finished && !dp_status_i.time_reached;
      end
      gsrs_pkg::CS_PROP_MUL: dp_cmd_o.prop_mul = 1'b1;
      gsrs_pkg::CS_PROP_K:   dp_cmd_o.prop_k   = 1'b1;
      gsrs_pkg::CS_PROP_ACC: dp_cmd_o.prop_acc = 1'b1;
      gsrs_pkg::CS_ZERO_CHK: dp_cmd_o.set_finished = dp_status_i.total_zero;
      gsrs_pkg::CS_THR_MUL:  dp_cmd_o.thr_mul  = 1'b1;
      gsrs_pkg::CS_THR_FIN:  dp_cmd_o.thr_fin  = 1'b1;
      gsrs_pkg::CS_SELECT:   dp_cmd_o.sel      = 1'b1;
      gsrs_pkg::CS_WAIT_LOG: begin
        dp_cmd_o.div_start = dp_status_i.log_done && !dp_status_i.total_big;
      end
      gsrs_pkg::CS_DIVIDE: ;
      gsrs_pkg::CS_FINAL: begin
        dp_cmd_o.commit       = 1'b1;
        dp_cmd_o.set_finished = dp_status_i.t_over;
        dp_cmd_o.apply        = !dp_status_i.t_over;
      end
      gsrs_pkg::CS_EMIT: dp_cmd_o.emit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (dp_cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsrs_pkg::CS_IDLE;
      idx_q       <= '0;
      status_q    <= gsrs_pkg::ST_FIRED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == gsrs_pkg::CS_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/gillespie_surface_reaction_step.sv -----
// Top level of the Gillespie direct-method surface reaction step block.
//
// Input channel (in_valid_i/in_ready_o): each transfer carries a command.
// A load writes one species population and clears the run time and the
// finished flag; it gives no result. A step gives one result on the output
// channel (out_valid_o/out_ready_i): status, fired event, run time and all
// six populations after the step.
// A step ends early when the run is already over, when the time limit is
// reached at the start or when no reaction is possible, and skips the
// divider when the total is too large for it. Otherwise its result waits
// on the -ln unit (6 normalize steps and 28 squaring steps), which overlaps
// the propensity and event choice passes, followed by the restoring divider
// at one quotient bit per cycle. One step is in flight at a time;
// in_ready_o is high only while idle. The result sits in an output
// register, so the next command is taken while it waits; a stalled receiver
// holds back only the next step result. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i; the user writes it only while idle, and
// the block does not enforce this. Reset clears populations, time, finished
// flag, rates, time limit and control state.
module gillespie_surface_reaction_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [gsrs_pkg::SP_W-1:0]          species_index_i,
  input  logic [gsrs_pkg::POP_BITS-1:0]      population_i,
  input  logic [31:0]                        uniform_a_i,
  input  logic [31:0]                        uniform_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [gsrs_pkg::EV_W-1:0]          event_index_o,
  output logic [gsrs_pkg::TIME_W-1:0]        elapsed_time_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_gas_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_free_ads_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_strong_ads_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_free_sites_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_strong_sites_o,
  output logic [gsrs_pkg::POP_BITS-1:0]      pop_molecules_o,
  input  logic                               cfg_we_i,
  input  logic [gsrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gsrs_pkg::CFG_W-1:0]         cfg_data_i
);

  gsrs_pkg::dp_cmd_t    dp_cmd;
  gsrs_pkg::dp_status_t dp_status;
  logic [gsrs_pkg::NSPEC-1:0][gsrs_pkg::POP_BITS-1:0] pops;

  // Sequencer: accepts commands, walks the step phases, holds output valid.
  gsrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath: run state, rates, arithmetic units and the result register.
  gsrs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .species_index_i (species_index_i),
    .population_i    (population_i),
    .uniform_a_i     (uniform_a_i),
    .uniform_b_i     (uniform_b_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .status_out_o    (status_o),
    .event_out_o     (event_index_o),
    .time_out_o      (elapsed_time_o),
    .pop_out_o       (pops)
  );

  // Fan the result populations out to their own ports.
  assign pop_gas_o          = pops[gsrs_pkg::SP_GAS];
  assign pop_free_ads_o     = pops[gsrs_pkg::SP_FREE_ADS];
  assign pop_strong_ads_o   = pops[gsrs_pkg::SP_STRONG_ADS];
  assign pop_free_sites_o   = pops[gsrs_pkg::SP_FREE_SITE];
  assign pop_strong_sites_o = pops[gsrs_pkg::SP_STRONG_SITE];
  assign pop_molecules_o    = pops[gsrs_pkg::SP_MOLECULE];

  // A step transfer closes the input side until its result is issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == gsrs_pkg::CMD_STEP) |=> !in_ready_o)
    else $error("input accepted while a step is in flight");

  // Never overwrite a result that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

  // Only a fired event carries a nonzero event index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != gsrs_pkg::ST_FIRED) |-> (event_index_o == '0))
    else $error("event index set on a non-firing result");

  // An event is applied only on a step that does not end the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.apply |-> (!dp_cmd.set_finished && dp_cmd.commit))
    else $error("event applied on a finishing step");

endmodule
